// ----- hw/rtl/ovle_pkg.sv -----
// types, codes and states shared by the ordered value list engine
`default_nettype none

package ovle_pkg;

    // request actions
    localparam logic [1:0] ACT_APPEND = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_MODIFY = 2'd2;
    localparam logic [1:0] ACT_SEARCH = 2'd3;

    // result status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 5;

    // request payload
    typedef struct packed {
        logic [1:0]                action;
        logic signed [VALUE_W-1:0] key;
        logic signed [VALUE_W-1:0] new_value;
    } ovle_req_t;

    // result payload
    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] entry_count;
    } ovle_rsp_t;

    // finished result offered by the sequencer to the output stage
    typedef struct packed {
        logic      valid;
        ovle_rsp_t data;
    } ovle_res_t;

    // sequencer states
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SCAN,
        SEQ_SHIFT,
        SEQ_RESULT
    } ovle_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ovle_ram.sv -----
// generic simple dual-port ram with one write port and a registered read port
`default_nettype none

module ovle_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read, old data on a same-address collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ovle_seq.sv -----
// request sequencer: append, scan for first match, modify and shift-down delete
`default_nettype none

module ovle_seq
    import ovle_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     req_valid,
    input  wire ovle_req_t                req,
    output logic                          req_stall,
    input  wire logic                     res_take,
    output ovle_res_t                     res,
    output logic                          mem_we,
    output logic [$clog2(DEPTH)-1:0]      mem_waddr,
    output logic [VALUE_W-1:0]            mem_wdata,
    output logic                          mem_re,
    output logic [$clog2(DEPTH)-1:0]      mem_raddr,
    input  wire logic [VALUE_W-1:0]       mem_rdata
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    ovle_state_t      state_reg,    state_next;
    logic [CW-1:0]    count_reg,    count_next;
    logic             rd_pend_reg,  rd_pend_next;
    logic [1:0]       act_reg,      act_next;
    logic [VALUE_W-1:0] key_reg,    key_next;
    logic [VALUE_W-1:0] val_reg,    val_next;
    logic [1:0]       status_reg,   status_next;
    logic [AW-1:0]    scan_idx_reg, scan_idx_next;
    logic [AW-1:0]    rd_idx_reg,   rd_idx_next;
    logic [AW-1:0]    sh_dst_reg,   sh_dst_next;

    logic [CW-1:0]    count_m1;
    logic [AW-1:0]    last_idx;
    logic             full;

    assign count_m1 = count_reg - CW'(1);
    assign last_idx = count_m1[AW-1:0];
    assign full     = (count_reg == CW'(DEPTH));

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= SEQ_IDLE;
            count_reg   <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    // request and index holding registers
    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        status_reg   <= status_next;
        scan_idx_reg <= scan_idx_next;
        rd_idx_reg   <= rd_idx_next;
        sh_dst_reg   <= sh_dst_next;
    end

    // next state, memory accesses and result
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        act_next      = act_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        status_next   = status_reg;
        scan_idx_next = scan_idx_reg;
        rd_idx_next   = scan_idx_reg;
        sh_dst_next   = sh_dst_reg;
        mem_we        = 1'b0;
        mem_waddr     = sh_dst_reg;
        mem_wdata     = mem_rdata;
        mem_re        = 1'b0;
        mem_raddr     = scan_idx_reg;

        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (req_valid)
                begin
                    act_next      = req.action;
                    key_next      = req.key;
                    val_next      = req.new_value;
                    scan_idx_next = '0;
                    state_next    = SEQ_RESULT;
                    status_next   = ST_DONE;
                    if (req.action == ACT_APPEND)
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            // append goes straight to the tail slot
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[AW-1:0];
                            mem_wdata  = req.new_value;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        state_next = SEQ_SCAN;
                    end
                end
            end

            SEQ_SCAN:
            begin
                // issue the next read while comparing the one in flight
                mem_re    = 1'b1;
                mem_raddr = scan_idx_reg;
                if (scan_idx_reg != last_idx)
                begin
                    scan_idx_next = scan_idx_reg + AW'(1);
                end
                if (rd_pend_reg)
                begin
                    if (mem_rdata == key_reg)
                    begin
                        status_next = ST_DONE;
                        state_next  = SEQ_RESULT;
                        unique case (act_reg)
                            ACT_APPEND:
                            begin
                                state_next = SEQ_RESULT;
                            end
                            ACT_SEARCH:
                            begin
                                state_next = SEQ_RESULT;
                            end
                            ACT_MODIFY:
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = rd_idx_reg;
                                mem_wdata = val_reg;
                            end
                            ACT_DELETE:
                            begin
                                if (rd_idx_reg == last_idx)
                                begin
                                    count_next = count_m1;
                                end
                                else
                                begin
                                    // fetch the successor of the matched slot
                                    mem_raddr   = rd_idx_reg + AW'(1);
                                    sh_dst_next = rd_idx_reg;
                                    state_next  = SEQ_SHIFT;
                                end
                            end
                        endcase
                    end
                    else if (rd_idx_reg == last_idx)
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = SEQ_RESULT;
                    end
                end
            end

            SEQ_SHIFT:
            begin
                // move one entry down a slot per cycle
                mem_we    = 1'b1;
                mem_waddr = sh_dst_reg;
                mem_wdata = mem_rdata;
                if ((sh_dst_reg + AW'(1)) == last_idx)
                begin
                    count_next  = count_m1;
                    status_next = ST_DONE;
                    state_next  = SEQ_RESULT;
                end
                else
                begin
                    mem_re      = 1'b1;
                    mem_raddr   = sh_dst_reg + AW'(2);
                    sh_dst_next = sh_dst_reg + AW'(1);
                end
            end

            SEQ_RESULT:
            begin
                if (res_take)
                begin
                    state_next = SEQ_IDLE;
                end
            end

            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase

        rd_pend_next = (state_reg == SEQ_SCAN) && (state_next == SEQ_SCAN);
    end

    assign req_stall            = (state_reg != SEQ_IDLE);
    assign res.valid            = (state_reg == SEQ_RESULT);
    assign res.data.status      = status_reg;
    assign res.data.entry_count = COUNT_W'(count_reg);

`ifndef SYNTH
    // the list never holds more than the memory depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    // memory is written only while an item is being worked on
    a_write_ctx: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == SEQ_SCAN || state_reg == SEQ_SHIFT
                    || (state_reg == SEQ_IDLE && req_valid)))
        else $error("memory write outside an item");

    // shift reads ahead of the slot being written
    a_shift_sep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_SHIFT && mem_re) |-> (mem_raddr != mem_waddr))
        else $error("shift read collides with write");

    // count moves only when an item finishes
    a_count_move: assert property (@(posedge clk) disable iff (!rst_n)
        (count_next != count_reg) |=> (state_reg == SEQ_RESULT))
        else $error("count changed without a result");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/ordered_value_list_engine_core.sv -----
// top level of the ordered value list engine: sequencer, entry memory, output register
//
//   channel | direction | payload    | handshake
//   req     | in        | ovle_req_t | req_valid / req_stall
//   rsp     | out       | ovle_rsp_t | rsp_valid / rsp_stall
//
// one item at a time; append and empty-list requests go straight to the result
// state, while search, modify and delete scan the list with one compare per
// read, and a delete moves each later entry with one read and one write per cycle.
// reset clears the count, state and output valid; entries need no clearing since
// only slots below the count are read. a held result in the output register does
// not block a new request; a stalled output holds the sequencer in its result state.
`default_nettype none

module ordered_value_list_engine_core
    import ovle_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    input  wire ovle_req_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_stall,
    output ovle_rsp_t      rsp
);

    localparam int unsigned AW = $clog2(DEPTH);

    ovle_res_t          res;
    logic               res_take;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    logic               out_valid_reg, out_valid_next;
    ovle_rsp_t          out_data_reg,  out_data_next;

    // entry storage
    ovle_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // request sequencer
    ovle_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_stall (req_stall),
        .res_take  (res_take),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // output register loads when empty or when its transfer completes
    always_comb
    begin
        res_take       = res.valid && (!out_valid_reg || !rsp_stall);
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

endmodule

`default_nettype wire
